// ----- rtl/core/dxt_block_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// dxt block decoder assertion macros
// shared concurrent assertion forms for the decoder core
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_CORE_MACROS_SVH
`define DXT_BLOCK_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DXT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DXT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dxt_pkg.sv -----
// ----------------------------------------------------------------------------
// dxt block decoder package
// shared types, constants and constant-divide helpers
// ----------------------------------------------------------------------------
package dxt_pkg;

    // reciprocals for exact floor division, scaled by 2^DIV_SHIFT
    localparam int DIV_SHIFT = 20;
    localparam logic [18:0] RECIP3  = 19'd349526;
    localparam logic [18:0] RECIP5  = 19'd209716;
    localparam logic [18:0] RECIP7  = 19'd149797;
    localparam logic [18:0] RECIP31 = 19'd33826;
    localparam logic [18:0] RECIP63 = 19'd16645;

    localparam logic [3:0] LAST_PIXEL  = 4'd15;
    localparam logic [1:0] CIDX_TRANSP = 2'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // expanded endpoints plus indices
    typedef struct packed {
        rgb_t        c0;
        rgb_t        c1;
        logic        four;
        logic        dxt5;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [31:0] cidx;
        logic [47:0] aidx;
    } endp_t;

    // full palettes plus indices
    typedef struct packed {
        rgb_t [3:0]       cpal;
        logic             opaque3;
        logic             dxt5;
        logic [7:0][7:0]  apal;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
    } pal_t;

    // floor(x / d) by one multiply with a rounded-up reciprocal; exact for the
    // value ranges used here
    function automatic logic [7:0] div_recip(input logic [13:0] x, input logic [18:0] m);
        logic [32:0] p;
        p = 33'(x) * 33'(m);
        return 8'(p >> DIV_SHIFT);
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return div_recip(14'({v, 8'd0}) - 14'(v), RECIP31);
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return div_recip(14'({v, 8'd0}) - 14'(v), RECIP63);
    endfunction

endpackage

// ----- rtl/core/dxt_expand.sv -----
// ----------------------------------------------------------------------------
// dxt endpoint expansion stage
// widens the rgb565 endpoints to 8 bits and picks the color mode
// ----------------------------------------------------------------------------
module dxt_expand
    import dxt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_cb,
    input  logic [63:0] in_ab,
    input  logic        in_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output endp_t       out_ep
);

    logic  valid_reg;
    endp_t ep_reg;
    endp_t ep_next;
    logic [15:0] c0;
    logic [15:0] c1;

    assign c0 = in_cb[15:0];
    assign c1 = in_cb[31:16];

    always_comb
    begin
        ep_next.c0.r = expand5(c0[15:11]);
        ep_next.c0.g = expand6(c0[10:5]);
        ep_next.c0.b = expand5(c0[4:0]);
        ep_next.c1.r = expand5(c1[15:11]);
        ep_next.c1.g = expand6(c1[10:5]);
        ep_next.c1.b = expand5(c1[4:0]);
        ep_next.four = in_mode || (c0 > c1);
        ep_next.dxt5 = in_mode;
        ep_next.a0   = in_ab[7:0];
        ep_next.a1   = in_ab[15:8];
        ep_next.cidx = in_cb[63:32];
        ep_next.aidx = in_ab[63:16];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_ep    = ep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ep_reg <= ep_next;
        end
    end

endmodule

// ----- rtl/core/dxt_palette.sv -----
// ----------------------------------------------------------------------------
// dxt palette stage
// builds the four-entry color palette and eight-entry alpha palette
// ----------------------------------------------------------------------------
module dxt_palette
    import dxt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  endp_t in_ep,
    output logic  out_valid,
    input  logic  out_ready,
    output pal_t  out_pal
);

    logic valid_reg;
    pal_t pal_reg;
    pal_t pal_next;
    logic [7:0] c0_ch [3];
    logic [7:0] c1_ch [3];
    logic [7:0] mix2  [3];
    logic [7:0] mix3  [3];
    logic [10:0] sum7 [1:6];
    logic [10:0] sum5 [1:4];

    assign c0_ch[0] = in_ep.c0.r;
    assign c0_ch[1] = in_ep.c0.g;
    assign c0_ch[2] = in_ep.c0.b;
    assign c1_ch[0] = in_ep.c1.r;
    assign c1_ch[1] = in_ep.c1.g;
    assign c1_ch[2] = in_ep.c1.b;

    // per channel interpolation, four-color or three-color
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (in_ep.four)
            begin
                mix2[ch] = div_recip(14'({c0_ch[ch], 1'b0}) + 14'(c1_ch[ch]), RECIP3);
                mix3[ch] = div_recip(14'(c0_ch[ch]) + 14'({c1_ch[ch], 1'b0}), RECIP3);
            end
            else
            begin
                mix2[ch] = 8'((9'(c0_ch[ch]) + 9'(c1_ch[ch])) >> 1);
                mix3[ch] = 8'd0;
            end
        end
    end

    // weighted alpha sums
    always_comb
    begin
        for (int k = 1; k <= 6; k++)
        begin
            sum7[k] = 11'(7 - k) * 11'(in_ep.a0) + 11'(k) * 11'(in_ep.a1);
        end
        for (int k = 1; k <= 4; k++)
        begin
            sum5[k] = 11'(5 - k) * 11'(in_ep.a0) + 11'(k) * 11'(in_ep.a1);
        end
    end

    always_comb
    begin
        pal_next.cpal[0]   = in_ep.c0;
        pal_next.cpal[1]   = in_ep.c1;
        pal_next.cpal[2].r = mix2[0];
        pal_next.cpal[2].g = mix2[1];
        pal_next.cpal[2].b = mix2[2];
        pal_next.cpal[3].r = mix3[0];
        pal_next.cpal[3].g = mix3[1];
        pal_next.cpal[3].b = mix3[2];
        pal_next.opaque3   = in_ep.four;
        pal_next.dxt5      = in_ep.dxt5;
        pal_next.cidx      = in_ep.cidx;
        pal_next.aidx      = in_ep.aidx;
        pal_next.apal[0]   = in_ep.a0;
        pal_next.apal[1]   = in_ep.a1;
        if (in_ep.a0 > in_ep.a1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                pal_next.apal[k + 1] = div_recip(14'(sum7[k]), RECIP7);
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                pal_next.apal[k + 1] = div_recip(14'(sum5[k]), RECIP5);
            end
            pal_next.apal[6] = 8'd0;
            pal_next.apal[7] = ALPHA_OPAQUE;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pal   = pal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pal_reg <= pal_next;
        end
    end

endmodule

// ----- rtl/core/dxt_emit.sv -----
// ----------------------------------------------------------------------------
// dxt pixel emitter
// walks the sixteen pixels of a block into the output register
// ----------------------------------------------------------------------------
module dxt_emit
    import dxt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pal_t       in_pal,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha,
    output logic [1:0] pixel_x,
    output logic [1:0] pixel_y,
    output logic       last_pixel
);

    logic        blk_valid_reg;
    logic [3:0]  cnt_reg;
    pal_t        pal_reg;
    logic [31:0] cidx_reg;
    logic [47:0] aidx_reg;
    logic        out_valid_reg;
    rgb_t        rgb_reg;
    logic [7:0]  alpha_reg;
    logic [3:0]  pos_reg;
    logic        last_reg;

    logic        out_adv;
    logic        emit;
    logic        load;
    logic [1:0]  ci;
    logic [2:0]  ai;
    logic [7:0]  alpha_next;

    assign out_adv  = !out_valid_reg || out_ready;
    assign emit     = blk_valid_reg && out_adv;
    assign in_ready = !blk_valid_reg || (out_adv && (cnt_reg == LAST_PIXEL));
    assign load     = in_valid && in_ready;

    assign ci = cidx_reg[1:0];
    assign ai = aidx_reg[2:0];

    always_comb
    begin
        if (pal_reg.dxt5)
        begin
            alpha_next = pal_reg.apal[ai];
        end
        else if ((ci == CIDX_TRANSP) && !pal_reg.opaque3)
        begin
            alpha_next = 8'd0;
        end
        else
        begin
            alpha_next = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                blk_valid_reg <= in_valid;
            end
            if (emit)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (out_adv)
            begin
                out_valid_reg <= blk_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pal_reg  <= in_pal;
            cidx_reg <= in_pal.cidx;
            aidx_reg <= in_pal.aidx;
        end
        else if (emit)
        begin
            cidx_reg <= cidx_reg >> 2;
            aidx_reg <= aidx_reg >> 3;
        end
        if (emit)
        begin
            rgb_reg   <= pal_reg.cpal[ci];
            alpha_reg <= alpha_next;
            pos_reg   <= cnt_reg;
            last_reg  <= (cnt_reg == LAST_PIXEL);
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = rgb_reg.r;
    assign green      = rgb_reg.g;
    assign blue       = rgb_reg.b;
    assign alpha      = alpha_reg;
    assign pixel_x    = pos_reg[1:0];
    assign pixel_y    = pos_reg[3:2];
    assign last_pixel = last_reg;

endmodule

// ----- rtl/core/dxt_block_decoder_core.sv -----
// path: input register, expand, palette, emit block register, pixel output register
// throughput: one pixel word per cycle while m_axis_tready holds and blocks are waiting
// the pixel walk in dxt_emit sets the block rate; the three stages ahead of it buffer blocks
// reset: rst_n clears all valid flags, the pixel counter and format_mode (dxt1)
// ----------------------------------------------------------------------------
// dxt block decoder core
// decodes dxt1 / dxt5 4x4 blocks into sixteen rgba pixels in raster order
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_core_macros.svh"

module dxt_block_decoder_core
    import dxt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // format_mode: 0 = dxt1, 1 = dxt5
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    // block input word
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // color_block[63:0], alpha_block[127:64]
    // pixel output word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // red, green, blue, alpha, pixel_x, pixel_y, zero pad
    output logic         m_axis_tlast    // last_pixel
);

    // configuration register
    logic        format_mode_reg;

    // input register
    logic        in_valid_reg;
    logic [63:0] in_cb_reg;
    logic [63:0] in_ab_reg;
    logic        in_mode_reg;
    logic        in_ready;

    // stage links
    logic        exp_ready;
    logic        exp_valid;
    endp_t       exp_ep;
    logic        pal_ready;
    logic        pal_valid;
    pal_t        pal_data;
    logic        emit_ready;

    // pixel fields
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [1:0]  pixel_x;
    logic [1:0]  pixel_y;
    logic        last_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            format_mode_reg <= cfg_wr_data;
        end
    end

    // the input register frees as soon as the expand stage takes its word
    assign in_ready      = !in_valid_reg || exp_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // mode is captured with the block so each block decodes in its own format
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_ready)
        begin
            in_cb_reg   <= s_axis_tdata[63:0];
            in_ab_reg   <= s_axis_tdata[127:64];
            in_mode_reg <= format_mode_reg;
        end
    end

    // endpoint expansion: rgb565 to rgb888, mode choice
    dxt_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (exp_ready),
        .in_cb     (in_cb_reg),
        .in_ab     (in_ab_reg),
        .in_mode   (in_mode_reg),
        .out_valid (exp_valid),
        .out_ready (pal_ready),
        .out_ep    (exp_ep)
    );

    // color and alpha palettes
    dxt_palette u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exp_valid),
        .in_ready  (pal_ready),
        .in_ep     (exp_ep),
        .out_valid (pal_valid),
        .out_ready (emit_ready),
        .out_pal   (pal_data)
    );

    // sixteen-pixel walk into the output register
    dxt_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pal_valid),
        .in_ready   (emit_ready),
        .in_pal     (pal_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    assign m_axis_tdata = {4'd0, pixel_y, pixel_x, alpha, blue, green, red};
    assign m_axis_tlast = last_pixel;

    // the last word of a block sits at the bottom right corner
    `DXT_ASSERT_IMPLY(a_last_pos, clk, rst_n, m_axis_tvalid && m_axis_tlast, (pixel_x == 2'd3) && (pixel_y == 2'd3), "last pixel not at corner")

    // a block never pauses in the middle once its words are being taken
    `DXT_ASSERT_NEXT(a_no_gap, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a block")

    // pixel position steps by one within a block
    `DXT_ASSERT_NEXT(a_pos_step, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, {pixel_y, pixel_x} == $past({pixel_y, pixel_x}) + 4'd1, "pixel position skipped")

    // a stalled input register keeps its block
    `DXT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !exp_ready, in_valid_reg && $stable(in_cb_reg) && $stable(in_ab_reg), "input block lost while stalled")

endmodule
